@@ rtl/audio_peak_hold_rms_meter_assert.svh @@
// assertion macros shared by the level meter rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef AUDIO_PEAK_HOLD_RMS_METER_ASSERT_SVH
`define AUDIO_PEAK_HOLD_RMS_METER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must hold in the same cycle as the trigger
`define APHRM_ASSERT_SAME(name, clk, rst, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("level meter check failed");

// condition must hold in the cycle after the trigger
`define APHRM_ASSERT_NEXT(name, clk, rst, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("level meter check failed");

`else

`define APHRM_ASSERT_SAME(name, clk, rst, trig, cond)
`define APHRM_ASSERT_NEXT(name, clk, rst, trig, cond)

`endif

`endif

@@ rtl/aphrm_pkg.sv @@
// types, constants and codes for the peak hold / rms level meter
// no dependencies; used by every module of the block
`default_nettype none

package aphrm_pkg;

  // default sizes of the datapath
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ACC_BITS_DEF    = 48;

  // shared arithmetic unit
  localparam int ALU_W     = 64;
  localparam int MUL_W     = 32;
  localparam int Q24_SHIFT = 24;
  localparam int Q32_SHIFT = 32;

  // configuration registers
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MULT_W    = 24;
  localparam int HOLD_W    = 20;
  localparam int NORM_W    = 32;

  localparam logic [MULT_W-1:0] PEAK_DECAY_RST = MULT_W'(16775144);
  localparam logic [MULT_W-1:0] MEM_DECAY_RST  = MULT_W'(16776377);
  localparam logic [HOLD_W-1:0] HOLD_LEN_RST   = HOLD_W'(50000);
  localparam logic [NORM_W-1:0] RMS_NORM_RST   = NORM_W'(530500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_DECAY,
    REG_MEM_DECAY,
    REG_HOLD_LEN,
    REG_RMS_NORM
  } cfg_reg_t;

  typedef struct packed {
    logic [MULT_W-1:0] peak_decay;
    logic [MULT_W-1:0] mem_decay;
    logic [HOLD_W-1:0] hold_len;
    logic [NORM_W-1:0] rms_norm;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RP_MUL,
    S_DM_MUL,
    S_SQ_MUL,
    S_ACL_MUL,
    S_ACH_MUL,
    S_ACC_COMB,
    S_ACC_ADD,
    S_ACC_SAT,
    S_BE_PEAK,
    S_BE_HOLD,
    S_MEAN,
    S_SQ_INIT,
    S_SQ_SUB,
    S_SQ_UPD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/aphrm_alu.sv @@
// shared arithmetic unit: 32x32 multiply, 64-bit add and subtract, registered
// depends on aphrm_pkg
`default_nettype none

module aphrm_alu (
  input  logic                         clk,
  input  aphrm_pkg::alu_req_t          req,
  output logic [aphrm_pkg::ALU_W:0]    res
);
  import aphrm_pkg::*;

  logic [2*MUL_W-1:0] prod;

  // full width product of the low operand halves
  assign prod = req.a[MUL_W-1:0] * req.b[MUL_W-1:0];

  // one operation per cycle, result registered; top bit is carry or borrow, zero for a multiply
  always_ff @(posedge clk) begin
    unique case (req.op)
      ALU_MUL: res <= {1'b0, prod};
      ALU_ADD: res <= {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: res <= {1'b0, req.a} - {1'b0, req.b};
      default: res <= {1'b0, req.a};
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/aphrm_cfg.sv @@
// configuration register file of the level meter, write only
// depends on aphrm_pkg
`default_nettype none

module aphrm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [aphrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aphrm_pkg::CFG_W-1:0]     cfg_data,
  output aphrm_pkg::cfg_t                cfg
);
  import aphrm_pkg::*;

  // register writes, each value cut to its register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_decay <= PEAK_DECAY_RST;
      cfg.mem_decay  <= MEM_DECAY_RST;
      cfg.hold_len   <= HOLD_LEN_RST;
      cfg.rms_norm   <= RMS_NORM_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PEAK_DECAY: cfg.peak_decay <= cfg_data[MULT_W-1:0];
        REG_MEM_DECAY:  cfg.mem_decay  <= cfg_data[MULT_W-1:0];
        REG_HOLD_LEN:   cfg.hold_len   <= cfg_data[HOLD_W-1:0];
        REG_RMS_NORM:   cfg.rms_norm   <= cfg_data[NORM_W-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/aphrm_core.sv @@
// sequencer and meter state: decays, square sum, hold logic and square root
// depends on aphrm_pkg and audio_peak_hold_rms_meter_assert.svh, drives the shared unit aphrm_alu
`default_nettype none

`include "audio_peak_hold_rms_meter_assert.svh"

module aphrm_core #(
  parameter int SAMPLE_BITS = aphrm_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = aphrm_pkg::ACC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  aphrm_pkg::cfg_t               cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          block_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SAMPLE_BITS-2:0]        level_peak,
  output logic [SAMPLE_BITS-2:0]        memory_peak,
  output logic [SAMPLE_BITS-2:0]        rms_level,
  output aphrm_pkg::alu_req_t           alu_req,
  input  logic [aphrm_pkg::ALU_W:0]     alu_res
);
  import aphrm_pkg::*;

  localparam int MW = SAMPLE_BITS - 1;
  localparam int SW = 2 * MW;
  localparam int AW = ACC_BITS;

  state_t state, state_next;

  // meter state
  logic [MW-1:0]     rpk, smp, dmp, bmax;
  logic [AW-1:0]     acc;
  logic [HOLD_W-1:0] hold;

  // per item working registers
  logic [MW-1:0]    mag, sq;
  logic             blk_end;
  logic [ALU_W-1:0] prod_lo;
  logic [SW-1:0]    sv, sr, sbit;

  logic              out_load;
  logic [SAMPLE_BITS-1:0] raw, abs_val;
  logic [MW-1:0]     mag_in, bmax_upd, dsel, smp_be;
  logic [HOLD_W-1:0] hold_inc, hold_be;
  logic              acc_ovf, mean_big, sqrt_ge;

  // magnitude of the incoming sample, most negative code saturates
  assign raw     = sample_value;
  assign abs_val = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign mag_in  = abs_val[SAMPLE_BITS-1] ? {MW{1'b1}} : abs_val[MW-1:0];

  // small compares on narrow state
  assign bmax_upd = (mag > bmax) ? mag : bmax;
  assign hold_inc = (&hold) ? hold : hold + 1'b1;
  assign hold_be  = (rpk >= dmp) ? '0 : hold;
  assign dsel     = (hold_be < cfg.hold_len) ? smp : dmp;
  assign smp_be   = (rpk > dsel) ? rpk : dsel;

  // flags taken from the shared unit result, a carry out of the mean counts as big
  assign acc_ovf  = |(alu_res >> AW);
  assign mean_big = |(alu_res >> MW);
  assign sqrt_ge  = ~alu_res[ALU_W];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_RP_MUL;
      S_RP_MUL:   state_next = S_DM_MUL;
      S_DM_MUL:   state_next = S_SQ_MUL;
      S_SQ_MUL:   state_next = S_ACL_MUL;
      S_ACL_MUL:  state_next = S_ACH_MUL;
      S_ACH_MUL:  state_next = S_ACC_COMB;
      S_ACC_COMB: state_next = S_ACC_ADD;
      S_ACC_ADD:  state_next = S_ACC_SAT;
      S_ACC_SAT:  state_next = blk_end ? S_BE_PEAK : S_IDLE;
      S_BE_PEAK:  state_next = S_BE_HOLD;
      S_BE_HOLD:  state_next = S_MEAN;
      S_MEAN:     state_next = S_SQ_INIT;
      S_SQ_INIT:  state_next = mean_big ? S_DONE : S_SQ_SUB;
      S_SQ_SUB:   state_next = S_SQ_UPD;
      S_SQ_UPD:   state_next = sbit[0] ? S_DONE : S_SQ_SUB;
      S_DONE:     if (out_load) state_next = S_IDLE;
    endcase
  end

  // shared unit requests and handshake outputs
  always_comb begin
    alu_req  = '{op: ALU_ADD, a: '0, b: '0};
    in_stall = (state != S_IDLE);
    out_load = (state == S_DONE) && (!out_valid || !out_stall);
    unique case (state)
      S_RP_MUL:   alu_req = '{op: ALU_MUL, a: ALU_W'(rpk), b: ALU_W'(cfg.peak_decay)};
      S_DM_MUL:   alu_req = '{op: ALU_MUL, a: ALU_W'(dmp), b: ALU_W'(cfg.mem_decay)};
      S_SQ_MUL:   alu_req = '{op: ALU_MUL, a: ALU_W'(mag), b: ALU_W'(mag)};
      S_ACL_MUL:  alu_req = '{op: ALU_MUL, a: ALU_W'(acc[MUL_W-1:0]),
                              b: ALU_W'(cfg.peak_decay)};
      S_ACH_MUL:  alu_req = '{op: ALU_MUL, a: ALU_W'(acc >> MUL_W),
                              b: ALU_W'(cfg.peak_decay)};
      S_ACC_COMB: alu_req = '{op: ALU_ADD,
                              a: alu_res[ALU_W-1:0] << (MUL_W - Q24_SHIFT),
                              b: prod_lo >> Q24_SHIFT};
      S_ACC_ADD:  alu_req = '{op: ALU_ADD, a: alu_res[ALU_W-1:0], b: ALU_W'(sq)};
      S_BE_PEAK:  alu_req = '{op: ALU_MUL, a: ALU_W'(acc[MUL_W-1:0]),
                              b: ALU_W'(cfg.rms_norm)};
      S_BE_HOLD:  alu_req = '{op: ALU_MUL, a: ALU_W'(acc >> MUL_W),
                              b: ALU_W'(cfg.rms_norm)};
      S_MEAN:     alu_req = '{op: ALU_ADD, a: alu_res[ALU_W-1:0],
                              b: prod_lo >> Q32_SHIFT};
      S_SQ_SUB:   alu_req = '{op: ALU_SUB, a: ALU_W'(sv), b: ALU_W'(sr | sbit)};
      default:    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    endcase
  end

  // state register, meter state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rpk       <= '0;
      smp       <= '0;
      dmp       <= '0;
      bmax      <= '0;
      acc       <= '0;
      hold      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_DM_MUL:  rpk <= MW'(alu_res >> Q24_SHIFT);
        S_SQ_MUL:  dmp <= MW'(alu_res >> Q24_SHIFT);
        S_ACC_SAT: begin
          acc  <= acc_ovf ? {AW{1'b1}} : alu_res[AW-1:0];
          bmax <= bmax_upd;
          hold <= hold_inc;
        end
        S_BE_PEAK: begin
          if (bmax > rpk) rpk <= bmax;
          bmax <= '0;
        end
        S_BE_HOLD: begin
          hold <= hold_be;
          smp  <= smp_be;
          dmp  <= smp_be;
        end
        default: ;
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      level_peak  <= rpk;
      memory_peak <= smp;
      rms_level   <= sr[MW-1:0];
    end
    unique case (state)
      S_IDLE: if (in_valid) begin
        mag     <= mag_in;
        blk_end <= block_end;
      end
      S_ACL_MUL: sq <= MW'(alu_res >> MW);
      S_ACH_MUL: prod_lo <= alu_res[ALU_W-1:0];
      S_BE_HOLD: prod_lo <= alu_res[ALU_W-1:0];
      S_SQ_INIT: begin
        sv   <= {alu_res[MW-1:0], {MW{1'b0}}};
        sr   <= mean_big ? SW'({MW{1'b1}}) : '0;
        sbit <= {2'b01, {(SW-2){1'b0}}};
      end
      S_SQ_UPD: begin
        if (sqrt_ge) begin
          sv <= alu_res[SW-1:0];
          sr <= (sr >> 1) | sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
      end
      default: ;
    endcase
  end

  // checks on the sequencer and the block end update
  `APHRM_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)
  `APHRM_ASSERT_NEXT(a_bmax_clear, clk, rst, state == S_BE_PEAK, bmax == '0)
  `APHRM_ASSERT_NEXT(a_mem_ge_peak, clk, rst, state == S_BE_HOLD, smp >= rpk && dmp == smp)
  `APHRM_ASSERT_SAME(a_sqrt_bit, clk, rst, state == S_SQ_SUB || state == S_SQ_UPD, $onehot(sbit))

endmodule

`default_nettype wire

@@ rtl/audio_peak_hold_rms_meter.sv @@
// audio level meter top: decaying peak, held memory peak and rms, one channel
// an item without block end runs the decays and square sum before the next accept
// block end: the mean and the square root follow, then the result and next accept;
// a saturating rms skips the root, which takes S_SQ_SUB and S_SQ_UPD per result bit;
// a stalled result that still fills the output holds the next one back
// reset is synchronous: meter state clears, registers take their defaults; needs aphrm_*
`default_nettype none

module audio_peak_hold_rms_meter #(
  parameter int SAMPLE_BITS = aphrm_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = aphrm_pkg::ACC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [aphrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aphrm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   sample_value,
  input  logic                            block_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [SAMPLE_BITS-2:0]          level_peak,
  output logic [SAMPLE_BITS-2:0]          memory_peak,
  output logic [SAMPLE_BITS-2:0]          rms_level
);
  import aphrm_pkg::*;

  cfg_t             cfg;
  alu_req_t         alu_req;
  logic [ALU_W:0]   alu_res;

  // configuration registers
  aphrm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // shared arithmetic unit
  aphrm_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res)
  );

  // sequencer and meter state
  aphrm_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level_peak   (level_peak),
    .memory_peak  (memory_peak),
    .rms_level    (rms_level),
    .alu_req      (alu_req),
    .alu_res      (alu_res)
  );

endmodule

`default_nettype wire

@@ sim/audio_peak_hold_rms_meter_tb.sv @@
// self-checking testbench for the peak hold / rms level meter
// drives samples through valid/stall, predicts every result and compares it
// depends on aphrm_pkg and audio_peak_hold_rms_meter
`default_nettype none

module audio_peak_hold_rms_meter_tb;
  import aphrm_pkg::*;

  localparam int SB              = SAMPLE_BITS_DEF;
  localparam int AB              = ACC_BITS_DEF;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int PHASES          = 10;
  localparam int PHASE_ITEMS     = 163;

  localparam logic [SB-1:0] MOST_NEG   = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] LOUDEST    = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-2:0] FULL_SCALE = '1;
  localparam logic [AB-1:0] ACC_MAX    = '1;
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  typedef struct {
    logic signed [SB-1:0] value;
    logic                 last;
  } sample_item_t;

  typedef struct {
    logic [SB-2:0] level_peak;
    logic [SB-2:0] memory_peak;
    logic [SB-2:0] rms_level;
  } level_set_t;

  // dut ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SB-1:0] sample_value = '0;
  logic                 block_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SB-2:0]        level_peak;
  logic [SB-2:0]        memory_peak;
  logic [SB-2:0]        rms_level;

  // stimulus and prediction bookkeeping
  sample_item_t sample_queue[$];
  level_set_t   expected_levels[$];
  logic         taken = 1'b0;
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  int           err_count = 0;

  // register shadow
  logic [MULT_W-1:0] peak_decay_cfg;
  logic [MULT_W-1:0] mem_decay_cfg;
  logic [HOLD_W-1:0] hold_len_cfg;
  logic [NORM_W-1:0] rms_norm_cfg;

  // meter state shadow
  logic [SB-2:0]     run_peak;
  logic [SB-2:0]     mem_store;
  logic [SB-2:0]     mem_work;
  logic [AB-1:0]     sq_acc;
  logic [SB-2:0]     blk_max;
  logic [HOLD_W-1:0] hold_cnt;

  audio_peak_hold_rms_meter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level_peak   (level_peak),
    .memory_peak  (memory_peak),
    .rms_level    (rms_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(x * m / 2^24)
  function automatic logic [AB-1:0] scale_q24(logic [AB-1:0] x, logic [MULT_W-1:0] m);
    logic [AB+MULT_W-1:0] prod;
    prod = (AB+MULT_W)'(x) * (AB+MULT_W)'(m);
    return prod[AB+MULT_W-1:Q24_SHIFT];
  endfunction

  // integer square root, one result bit per pass from the top
  function automatic logic [SB-2:0] root_of(logic [2*SB-3:0] v);
    logic [SB-2:0]   r;
    logic [2*SB-3:0] trial;
    r = '0;
    for (int b = SB - 2; b >= 0; b--) begin
      r[b] = 1'b1;
      trial = (2*SB-2)'(r) * (2*SB-2)'(r);
      if (trial > v) r[b] = 1'b0;
    end
    return r;
  endfunction

  // one accepted sample: decay, accumulate and on block end form the levels
  function automatic void advance_meter(logic signed [SB-1:0] value, logic last);
    logic [SB-2:0] mag;
    logic [SB-2:0] sq;
    logic [AB+NORM_W-1:0] mean_full;
    logic [AB-1:0] mean;
    level_set_t res;
    if (value == MOST_NEG) mag = FULL_SCALE;
    else if (value < 0) mag = (SB-1)'(-value);
    else mag = value[SB-2:0];

    run_peak = (SB-1)'(scale_q24(AB'(run_peak), peak_decay_cfg));
    mem_work = (SB-1)'(scale_q24(AB'(mem_work), mem_decay_cfg));
    sq_acc = scale_q24(sq_acc, peak_decay_cfg);
    sq = (SB-1)'(((2*SB-2)'(mag) * (2*SB-2)'(mag)) >> (SB - 1));
    if (sq_acc > ACC_MAX - AB'(sq)) sq_acc = ACC_MAX;
    else sq_acc = sq_acc + AB'(sq);
    if (mag > blk_max) blk_max = mag;
    if (hold_cnt < HOLD_MAX) hold_cnt = hold_cnt + 1'b1;
    if (!last) return;

    // block end: peak merge, hold logic, memory update
    if (blk_max > run_peak) run_peak = blk_max;
    if (run_peak >= mem_work) hold_cnt = '0;
    if (hold_cnt < hold_len_cfg) mem_work = mem_store;
    mem_store = (run_peak > mem_work) ? run_peak : mem_work;
    mem_work = mem_store;
    blk_max = '0;

    mean_full = (AB+NORM_W)'(sq_acc) * (AB+NORM_W)'(rms_norm_cfg);
    mean = mean_full[AB+NORM_W-1:Q32_SHIFT];
    res.level_peak = run_peak;
    res.memory_peak = mem_store;
    if (mean >= AB'(1) << (SB - 1)) res.rms_level = FULL_SCALE;
    else res.rms_level = root_of({mean[SB-2:0], {(SB-1){1'b0}}});
    expected_levels.push_back(res);
  endfunction

  function automatic void report_mismatch(string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // accept on the input side, predict from the accepted item
  always @(posedge clk) begin
    taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) advance_meter(sample_value, block_end);
  end

  // sender: next item after an accept, with random gaps
  always @(negedge clk) begin : sample_driver
    sample_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (sample_queue.size() != 0 && (no_idle || $urandom_range(99) >= 14)) begin
        nxt = sample_queue.pop_front();
        sample_value <= nxt.value;
        block_end <= nxt.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 14);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : level_check
    level_set_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result: peak %0d mem %0d rms %0d",
                                  level_peak, memory_peak, rms_level));
      end else begin
        want = expected_levels.pop_front();
        if (want.level_peak !== level_peak || want.memory_peak !== memory_peak ||
            want.rms_level !== rms_level)
          report_mismatch($sformatf(
            "level mismatch: expected peak %0d mem %0d rms %0d, got peak %0d mem %0d rms %0d",
            want.level_peak, want.memory_peak, want.rms_level,
            level_peak, memory_peak, rms_level));
      end
    end
  end

  task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    case (which)
      REG_PEAK_DECAY: peak_decay_cfg = value[MULT_W-1:0];
      REG_MEM_DECAY:  mem_decay_cfg = value[MULT_W-1:0];
      REG_HOLD_LEN:   hold_len_cfg = value[HOLD_W-1:0];
      REG_RMS_NORM:   rms_norm_cfg = value[NORM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [MULT_W-1:0] pd, logic [MULT_W-1:0] md,
                           logic [HOLD_W-1:0] hl, logic [NORM_W-1:0] rn);
    write_reg(REG_PEAK_DECAY, CFG_W'(pd));
    write_reg(REG_MEM_DECAY, CFG_W'(md));
    write_reg(REG_HOLD_LEN, CFG_W'(hl));
    write_reg(REG_RMS_NORM, CFG_W'(rn));
  endtask

  task automatic queue_item(logic signed [SB-1:0] v, logic e);
    sample_queue.push_back('{value: v, last: e});
  endtask

  // wait until every item is in, every result out, and the block has gone quiet
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] random_sample();
    case ($urandom_range(9))
      0: return MOST_NEG;
      1: return LOUDEST;
      2: return '0;
      3: return SB'(int'($urandom_range(511)) - 256);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [MULT_W-1:0] pick_mult();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return MULT_W'($urandom);
      default: return MULT_W'(24'hFFFFFF - $urandom_range(20000));
    endcase
  endfunction

  function automatic logic [HOLD_W-1:0] pick_hold();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return HOLD_W'($urandom);
      default: return HOLD_W'($urandom_range(300));
    endcase
  endfunction

  function automatic logic [NORM_W-1:0] pick_norm();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return NORM_W'($urandom);
      default: return NORM_W'(32'hFFFFFFFF / $urandom_range(2, 5000));
    endcase
  endfunction

  // blocks of random samples, mostly short, the last one possibly left open
  task automatic queue_blocks(int count, int short_len);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, short_len) : $urandom_range(1, 60);
      for (int k = 0; k < len && left > 0; k++) begin
        queue_item(random_sample(), k == len - 1);
        left--;
      end
    end
  endtask

  initial begin : stimulus
    peak_decay_cfg = PEAK_DECAY_RST;
    mem_decay_cfg = MEM_DECAY_RST;
    hold_len_cfg = HOLD_LEN_RST;
    rms_norm_cfg = RMS_NORM_RST;
    run_peak = '0;
    mem_store = '0;
    mem_work = '0;
    sq_acc = '0;
    blk_max = '0;
    hold_cnt = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default settings: extremes, most negative sample, alternating bits
    write_all(PEAK_DECAY_RST, MEM_DECAY_RST, HOLD_LEN_RST, RMS_NORM_RST);
    queue_item('0, 1'b1);
    queue_item(LOUDEST, 1'b1);
    queue_item(MOST_NEG, 1'b1);
    queue_item(SB'(1), 1'b0);
    queue_item(-SB'(1), 1'b0);
    queue_item(-SB'(8388607), 1'b1);
    queue_item(SB'(24'h555555), 1'b0);
    queue_item(SB'(24'hAAAAAA), 1'b1);
    queue_item(SB'(100), 1'b1);
    queue_item('0, 1'b1);
    queue_item(-SB'(4096), 1'b0);
    queue_item(SB'(4096), 1'b0);
    drain();

    // open block carries over a register change; no hold, saturating rms
    write_all('1, MULT_W'(24'h800000), '0, '1);
    repeat (3) queue_item(LOUDEST, 1'b0);
    queue_item(LOUDEST, 1'b1);
    queue_item(SB'(1000), 1'b1);
    queue_item('0, 1'b1);
    queue_item(-SB'(5), 1'b1);
    queue_item('0, 1'b0);
    drain();

    // random phases, each under its own register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) write_all('1, '1, '1, '1);
      else if (ph == 1) write_all('0, '0, '0, '0);
      else if (ph == 2) write_all(pick_mult(), MULT_W'($urandom_range(24'hF00000)),
                                  HOLD_W'($urandom_range(40)), pick_norm());
      else write_all(pick_mult(), pick_mult(), pick_hold(), pick_norm());
      no_idle = (ph == 6);
      queue_blocks(PHASE_ITEMS, (ph == 3) ? 3 : 10);
      if (ph == 3) hold_req = 1'b1;
      drain();
    end
    no_idle = 1'b0;

    if (err_count == 0 && expected_levels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
